/* hw/rtl/bbcr_pkg.sv */
// Shared widths, stage types and saturating helpers for the box collision unit.
`default_nettype none

package bbcr_pkg;

	localparam int QW  = 18;
	localparam int PNW = 34;
	localparam int PDW = 18;
	localparam int VNW = 46;
	localparam int VDW = 28;

	typedef struct packed {
		logic [31:0] pos_first;
		logic [31:0] pos_second;
		logic [31:0] vel_first;
		logic [31:0] vel_second;
		logic        mv_first;
		logic        mv_second;
		logic        hit;
		logic        ax_y;
		logic        sg_neg;
		logic        appr;
	} side_t;

	function automatic logic [15:0] sat16(input logic signed [19:0] v);
		if (v > 20'sd32767) begin
			return 16'h7fff;
		end else if (v < -20'sd32768) begin
			return 16'h8000;
		end else begin
			return v[15:0];
		end
	endfunction

	function automatic logic [15:0] push(input logic [15:0] val, input logic [QW-1:0] q,
			input logic neg);
		logic signed [19:0] a;
		logic signed [19:0] b;
		a = signed'({{4{val[15]}}, val});
		b = signed'(20'(q));
		return sat16(neg ? a - b : a + b);
	endfunction

	function automatic logic [31:0] apply(input logic [31:0] w, input logic ax_y,
			input logic [QW-1:0] q, input logic neg);
		if (ax_y) begin
			return {w[31:16], push(w[15:0], q, neg)};
		end else begin
			return {push(w[31:16], q, neg), w[15:0]};
		end
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/bbcr_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none

module bbcr_div
	import bbcr_pkg::*;
#(
	parameter int NW = PNW,
	parameter int DW = PDW,
	parameter int QN = QW
) (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] den,
	output logic      [QN-1:0] quo
);

	localparam int RW = (NW > DW + QN) ? NW : DW + QN;

	logic [RW-1:0] rem_s [QN-1];
	logic [DW-1:0] den_s [QN-1];
	logic [QN-1:0] q_s   [QN];

	for (genvar i = 0; i < QN; i++) begin : g_stage
		logic [RW-1:0] rem_in;
		logic [RW-1:0] dsh;
		logic [DW-1:0] den_in;
		logic [QN-1:0] q_in;
		logic          ge;

		if (i == 0) begin : g_first
			assign rem_in = RW'(num);
			assign den_in = den;
			assign q_in   = '0;
		end else begin : g_next
			assign rem_in = rem_s[i-1];
			assign den_in = den_s[i-1];
			assign q_in   = q_s[i-1];
		end

		assign dsh = RW'(den_in) << (QN - 1 - i);
		assign ge  = rem_in >= dsh;

		always_ff @(posedge clk) begin
			if (en) begin
				q_s[i] <= {q_in[QN-2:0], ge};
			end
		end

		if (i < QN - 1) begin : g_keep
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[i] <= ge ? rem_in - dsh : rem_in;
					den_s[i] <= den_in;
				end
			end
		end
	end

	assign quo = q_s[QN-1];

endmodule

`default_nettype wire

/* hw/rtl/box_box_collision_response_unit.sv */
// Top level of the box pair collision response pipeline.
// Takes one box pair per cycle unless the pipeline is held, and passes it through five
// stages of overlap test, axis pick and products, an 18-stage restoring divider
// (one quotient bit per stage) for the mass-weighted pushes and impulses, and
// an output register that applies and saturates them. While a result waits
// under out_stall the whole pipeline holds and in_stall is raised.
`default_nettype none

module box_box_collision_response_unit
	import bbcr_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [31:0] pos_first,
	input  wire logic [31:0] pos_second,
	input  wire logic [31:0] size_first,
	input  wire logic [31:0] size_second,
	input  wire logic [31:0] vel_first,
	input  wire logic [31:0] vel_second,
	input  wire logic [15:0] mass_first,
	input  wire logic [15:0] mass_second,
	input  wire logic [8:0]  bounce_first,
	input  wire logic [8:0]  bounce_second,
	input  wire logic        movable_first,
	input  wire logic        movable_second,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             hit,
	output logic      [31:0] new_pos_first,
	output logic      [31:0] new_pos_second,
	output logic      [31:0] new_vel_first,
	output logic      [31:0] new_vel_second
);

	localparam int NV = 6 + QW;

	logic          en;
	logic [NV-1:0] vld_s;

	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;
	assign out_valid = vld_s[NV-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[NV-2:0], in_valid};
		end
	end

	// stage 1: doubled center distance and overlap per axis
	logic signed [17:0] dx2, dy2;
	logic        [17:0] ax_abs, ay_abs;
	logic signed [18:0] ovx_c, ovy_c;
	side_t              side_s1;
	logic signed [18:0] ovx_s1, ovy_s1;
	logic               dnx_s1, dny_s1;
	logic        [15:0] m1_s1, m2_s1;
	logic        [8:0]  b1_s1, b2_s1;

	assign dx2 = {pos_second[31], pos_second[31:16], 1'b0} - {pos_first[31], pos_first[31:16], 1'b0};
	assign dy2 = {pos_second[15], pos_second[15:0], 1'b0} - {pos_first[15], pos_first[15:0], 1'b0};
	assign ax_abs = dx2[17] ? 18'(-dx2) : 18'(dx2);
	assign ay_abs = dy2[17] ? 18'(-dy2) : 18'(dy2);
	assign ovx_c = signed'({3'b000, size_first[31:16]} + {3'b000, size_second[31:16]}
		- {1'b0, ax_abs});
	assign ovy_c = signed'({3'b000, size_first[15:0]} + {3'b000, size_second[15:0]}
		- {1'b0, ay_abs});

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= '{pos_first: pos_first, pos_second: pos_second, vel_first: vel_first,
				vel_second: vel_second, mv_first: movable_first, mv_second: movable_second,
				hit: 1'b0, ax_y: 1'b0, sg_neg: 1'b0, appr: 1'b0};
			ovx_s1 <= ovx_c;
			ovy_s1 <= ovy_c;
			dnx_s1 <= dx2[17];
			dny_s1 <= dy2[17];
			m1_s1  <= mass_first;
			m2_s1  <= mass_second;
			b1_s1  <= bounce_first;
			b2_s1  <= bounce_second;
		end
	end

	// stage 2: axis, normal sign, closing speed, effective masses
	logic               ax_y_c, sg_c, appr_c;
	logic        [15:0] va1, va2;
	logic signed [16:0] dv_c;
	logic        [15:0] m1e_c, m2e_c;
	side_t              side_c2;
	side_t              side_s2;
	logic        [16:0] o_s2, msum_s2;
	logic        [15:0] s_s2, m1e_s2, m2e_s2;
	logic        [11:0] f1_s2, f2_s2;

	assign ax_y_c = !(ovx_s1 < ovy_s1);
	assign sg_c   = ax_y_c ? dny_s1 : dnx_s1;
	assign va1    = ax_y_c ? side_s1.vel_first[15:0]  : side_s1.vel_first[31:16];
	assign va2    = ax_y_c ? side_s1.vel_second[15:0] : side_s1.vel_second[31:16];
	assign dv_c   = {va2[15], va2} - {va1[15], va1};
	assign appr_c = sg_c ? (!dv_c[16] && dv_c != 17'sd0) : dv_c[16];

	always_comb begin
		side_c2        = side_s1;
		side_c2.hit    = !ovx_s1[18] && !ovy_s1[18];
		side_c2.ax_y   = ax_y_c;
		side_c2.sg_neg = sg_c;
		side_c2.appr   = appr_c;
	end

	always_comb begin
		case ({side_s1.mv_first, side_s1.mv_second})
			2'b11: begin
				if (m1_s1 == 16'd0 && m2_s1 == 16'd0) begin
					m1e_c = 16'd1;
					m2e_c = 16'd1;
				end else begin
					m1e_c = m1_s1;
					m2e_c = m2_s1;
				end
			end
			2'b01: begin
				m1e_c = 16'd1;
				m2e_c = 16'd0;
			end
			2'b10: begin
				m1e_c = 16'd0;
				m2e_c = 16'd1;
			end
			default: begin
				m1e_c = 16'd1;
				m2e_c = 16'd1;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2 <= side_c2;
			o_s2    <= ax_y_c ? ovy_s1[16:0] : ovx_s1[16:0];
			s_s2    <= dv_c[16] ? 16'(-dv_c) : 16'(dv_c);
			m1e_s2  <= m1e_c;
			m2e_s2  <= m2e_c;
			msum_s2 <= {1'b0, m1e_c} + {1'b0, m2e_c};
			f1_s2   <= 12'd768 + 12'({b1_s1, 1'b0}) + 12'(b2_s1);
			f2_s2   <= 12'd768 + 12'(b1_s1) + 12'({b2_s1, 1'b0});
		end
	end

	// stage 3: first products
	side_t        side_s3;
	logic [32:0]  pp1_s3, pp2_s3;
	logic [27:0]  sf1_s3, sf2_s3;
	logic [15:0]  m1e_s3, m2e_s3;
	logic [16:0]  msum_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			side_s3 <= side_s2;
			pp1_s3  <= o_s2 * m2e_s2;
			pp2_s3  <= o_s2 * m1e_s2;
			sf1_s3  <= s_s2 * f1_s2;
			sf2_s3  <= s_s2 * f2_s2;
			m1e_s3  <= m1e_s2;
			m2e_s3  <= m2e_s2;
			msum_s3 <= msum_s2;
		end
	end

	// stage 4: impulse products, push numerators
	side_t        side_s4;
	logic [43:0]  pv1_s4, pv2_s4;
	logic [33:0]  np1_s4, np2_s4;
	logic [16:0]  msum_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			side_s4 <= side_s3;
			pv1_s4  <= sf1_s3 * m2e_s3;
			pv2_s4  <= sf2_s3 * m1e_s3;
			np1_s4  <= 34'(pp1_s3) + 34'(msum_s3);
			np2_s4  <= 34'(pp2_s3) + 34'(msum_s3);
			msum_s4 <= msum_s3;
		end
	end

	// stage 5: impulse numerators with rounding term, divisors
	side_t           side_s5;
	logic [PNW-1:0]  np1_s5, np2_s5;
	logic [VNW-1:0]  nv1_s5, nv2_s5;
	logic [PDW-1:0]  dp_s5;
	logic [VDW-1:0]  dv_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			side_s5 <= side_s4;
			np1_s5  <= np1_s4;
			np2_s5  <= np2_s4;
			nv1_s5  <= VNW'({pv1_s4, 1'b0}) + VNW'({msum_s4, 9'b0}) + VNW'({msum_s4, 8'b0});
			nv2_s5  <= VNW'({pv2_s4, 1'b0}) + VNW'({msum_s4, 9'b0}) + VNW'({msum_s4, 8'b0});
			dp_s5   <= {msum_s4, 1'b0};
			dv_s5   <= VDW'({msum_s4, 10'b0}) + VDW'({msum_s4, 9'b0});
		end
	end

	// divider stages
	logic [QW-1:0] qp1, qp2, qv1, qv2;
	side_t         side_d [QW];

	bbcr_div #(.NW(PNW), .DW(PDW), .QN(QW)) u_div_p1 (
		.clk(clk), .en(en), .num(np1_s5), .den(dp_s5), .quo(qp1));
	bbcr_div #(.NW(PNW), .DW(PDW), .QN(QW)) u_div_p2 (
		.clk(clk), .en(en), .num(np2_s5), .den(dp_s5), .quo(qp2));
	bbcr_div #(.NW(VNW), .DW(VDW), .QN(QW)) u_div_v1 (
		.clk(clk), .en(en), .num(nv1_s5), .den(dv_s5), .quo(qv1));
	bbcr_div #(.NW(VNW), .DW(VDW), .QN(QW)) u_div_v2 (
		.clk(clk), .en(en), .num(nv2_s5), .den(dv_s5), .quo(qv2));

	always_ff @(posedge clk) begin
		if (en) begin
			side_d[0] <= side_s5;
			for (int i = 1; i < QW; i++) begin
				side_d[i] <= side_d[i-1];
			end
		end
	end

	// output stage: apply, saturate, pass through on miss
	side_t         sd;
	logic [QW-1:0] gp1, gp2, gv1, gv2;

	assign sd  = side_d[QW-1];
	assign gp1 = sd.mv_first  ? qp1 : '0;
	assign gp2 = sd.mv_second ? qp2 : '0;
	assign gv1 = (sd.mv_first  && sd.appr) ? qv1 : '0;
	assign gv2 = (sd.mv_second && sd.appr) ? qv2 : '0;

	always_ff @(posedge clk) begin
		if (en) begin
			hit <= sd.hit;
			new_pos_first  <= sd.hit ? apply(sd.pos_first,  sd.ax_y, gp1, !sd.sg_neg)
				: sd.pos_first;
			new_pos_second <= sd.hit ? apply(sd.pos_second, sd.ax_y, gp2, sd.sg_neg)
				: sd.pos_second;
			new_vel_first  <= sd.hit ? apply(sd.vel_first,  sd.ax_y, gv1, !sd.sg_neg)
				: sd.vel_first;
			new_vel_second <= sd.hit ? apply(sd.vel_second, sd.ax_y, gv2, sd.sg_neg)
				: sd.vel_second;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/bbcr_chk.sv */
// Port checker for the box collision unit, bound to the top level.
`default_nettype none

module bbcr_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic        hit,
	input wire logic [31:0] new_pos_first,
	input wire logic [31:0] new_vel_second
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(hit) && $stable(new_pos_first)
			&& $stable(new_vel_second))
		else $error("result changed while stalled");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("input stall without a held result");

	a_stall_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> out_valid)
		else $error("held result vanished during stall");

endmodule

bind box_box_collision_response_unit bbcr_chk u_bbcr_chk (
	.clk(clk), .arst_n(arst_n), .in_stall(in_stall), .out_valid(out_valid),
	.out_stall(out_stall), .hit(hit), .new_pos_first(new_pos_first),
	.new_vel_second(new_vel_second));

`default_nettype wire
